// ===== hdl/irc_pkg.sv =====
`default_nettype none
package irc_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
   localparam logic [24:0] MIN_RECORD = 25'd52;
   localparam logic [24:0] COUNT_MAX  = 25'h1FFFFFF;
   localparam logic [20:0] SEEN_MAX   = 21'h1FFFFF;

   localparam logic [1:0] CSR_MAX_BYTES = 2'd0;
   localparam logic [1:0] CSR_MAGIC     = 2'd1;
   localparam logic [1:0] CSR_VERSION   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic [3:0] PH_MAGIC   = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd1;
   localparam logic [3:0] PH_LEN0    = 4'd2;
   localparam logic [3:0] PH_STR0    = 4'd3;
   localparam logic [3:0] PH_LEN1    = 4'd4;
   localparam logic [3:0] PH_STR1    = 4'd5;
   localparam logic [3:0] PH_LEN2    = 4'd6;
   localparam logic [3:0] PH_STR2    = 4'd7;
   localparam logic [3:0] PH_TOTAL   = 4'd8;
   localparam logic [3:0] PH_CREATED = 4'd9;
   localparam logic [3:0] PH_UPDATED = 4'd10;
   localparam logic [3:0] PH_COUNT   = 4'd11;
   localparam logic [3:0] PH_RSTART  = 4'd12;
   localparam logic [3:0] PH_REND    = 4'd13;
   localparam logic [3:0] PH_DONE    = 4'd14;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [63:0] content_length;
      logic signed [63:0] created_stamp;
      logic signed [63:0] updated_stamp;
      logic [19:0]        range_count;
      logic [23:0]        url_length;
      logic [23:0]        tag_length;
      logic [23:0]        modified_length;
   } rsp_type;

   // One byte of reflected CRC-32: eight bit steps of the polynomial.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/index_record_checker.sv =====
// Latency: a verdict is presented in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the per-byte CRC step, counters and 64-bit
// compares all sit between the state registers and the result register.
// While a verdict waits untaken, input is held off; a byte can be taken again
// in the cycle the verdict leaves.
// Reset is synchronous and active high; it restores register defaults and an empty record.
`default_nettype none
module index_record_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire irc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output irc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   logic [24:0] max_bytes_ff;
   logic [31:0] magic_ff, version_ff;

   logic [31:0] tail_ff, tail_in;
   logic [2:0]  fill_ff, fill_in;
   logic [31:0] crc_ff, crc_in;
   logic [24:0] count_ff, count_in;
   logic        oversize_ff, oversize_in;
   logic [3:0]  phase_ff, phase_in;
   logic [31:0] fcount_ff, fcount_in;
   logic [63:0] shift_ff, shift_in;
   logic        magic_good_ff, magic_good_in;
   logic        version_good_ff, version_good_in;
   logic        serr_ff, serr_in;
   logic [63:0] total_ff, total_in, created_ff, created_in, updated_ff, updated_in;
   logic [31:0] left_ff, left_in;
   logic [20:0] seen_ff, seen_in;
   logic [63:0] rstart_ff, rstart_in, prev_end_ff, prev_end_in;
   logic        first_ff, first_in;
   logic [24:0] slen_ff [3];
   logic [24:0] slen_in [3];
   logic        rsp_valid_ff;
   irc_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= 25'd16777216;
         magic_ff     <= 32'h49505953;
         version_ff   <= 32'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            irc_pkg::CSR_MAX_BYTES: max_bytes_ff <= csr_data[24:0];
            irc_pkg::CSR_MAGIC:     magic_ff <= csr_data;
            irc_pkg::CSR_VERSION:   version_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Per-byte record state update and verdict.
   always_comb begin
      logic [7:0]  b;
      logic [63:0] v;
      logic [31:0] w;
      logic [3:0]  width;
      logic        is_str, done;
      logic [1:0]  k;
      logic [31:0] fc;
      logic [1:0]  st;
      tail_in = tail_ff; fill_in = fill_ff; crc_in = crc_ff; count_in = count_ff;
      oversize_in = oversize_ff; phase_in = phase_ff; fcount_in = fcount_ff;
      shift_in = shift_ff; magic_good_in = magic_good_ff;
      version_good_in = version_good_ff; serr_in = serr_ff; total_in = total_ff;
      created_in = created_ff; updated_in = updated_ff; left_in = left_ff;
      seen_in = seen_ff; rstart_in = rstart_ff; prev_end_in = prev_end_ff;
      first_in = first_ff; slen_in = slen_ff;
      b = tail_ff[7:0];
      v = '0; w = '0; done = 1'b0; k = 2'd0; fc = '0; st = irc_pkg::ST_OK;
      is_str = (phase_ff == irc_pkg::PH_STR0) || (phase_ff == irc_pkg::PH_STR1)
            || (phase_ff == irc_pkg::PH_STR2);
      width = ((phase_ff >= irc_pkg::PH_TOTAL && phase_ff <= irc_pkg::PH_UPDATED)
            || phase_ff == irc_pkg::PH_RSTART || phase_ff == irc_pkg::PH_REND)
            ? 4'd8 : 4'd4;
      rsp_in = '0;

      if (count_ff >= irc_pkg::COUNT_MAX) oversize_in = 1'b1;
      else count_in = count_ff + 25'd1;

      // A byte leaving the delay line belongs to the body.
      if (fill_ff >= 3'd4) begin
         crc_in = irc_pkg::crc_byte(crc_ff, b);
         if (phase_ff == irc_pkg::PH_DONE) begin
            serr_in = 1'b1;
         end else if (is_str) begin
            fcount_in = fcount_ff - 32'd1;
            if (fcount_in == 32'd0)
               phase_in = (phase_ff == irc_pkg::PH_STR2) ? irc_pkg::PH_TOTAL
                                                         : phase_ff + 4'd1;
         end else begin
            v = shift_ff | ({56'd0, b} << {fcount_ff[2:0], 3'b000});
            fc = fcount_ff + 32'd1;
            shift_in = v;
            fcount_in = fc;
            done = fc >= {28'd0, width};
         end
      end else begin
         fill_in = fill_ff + 3'd1;
      end
      tail_in = {req_data.byte_value, tail_ff[31:8]};

      // A finished field moves the parser on.
      if (done) begin
         w = v[31:0];
         fcount_in = '0;
         shift_in = '0;
         case (phase_ff)
            irc_pkg::PH_MAGIC: begin
               magic_good_in = (w == magic_ff); phase_in = irc_pkg::PH_VERSION;
            end
            irc_pkg::PH_VERSION: begin
               version_good_in = (w == version_ff); phase_in = irc_pkg::PH_LEN0;
            end
            irc_pkg::PH_TOTAL: begin total_in = v; phase_in = irc_pkg::PH_CREATED; end
            irc_pkg::PH_CREATED: begin created_in = v; phase_in = irc_pkg::PH_UPDATED; end
            irc_pkg::PH_UPDATED: begin updated_in = v; phase_in = irc_pkg::PH_COUNT; end
            irc_pkg::PH_COUNT: begin
               left_in = w;
               phase_in = (w == 32'd0) ? irc_pkg::PH_DONE : irc_pkg::PH_RSTART;
            end
            irc_pkg::PH_RSTART: begin rstart_in = v; phase_in = irc_pkg::PH_REND; end
            irc_pkg::PH_REND: begin
               if (rstart_ff[63]) serr_in = 1'b1;
               if (!($signed(rstart_ff) < $signed(v))) serr_in = 1'b1;
               if (!total_ff[63] && ($signed(total_ff) < $signed(v))) serr_in = 1'b1;
               if (!first_ff && !($signed(prev_end_ff) < $signed(rstart_ff)))
                  serr_in = 1'b1;
               prev_end_in = v;
               first_in = 1'b0;
               if (seen_ff < irc_pkg::SEEN_MAX) seen_in = seen_ff + 21'd1;
               left_in = left_ff - 32'd1;
               phase_in = (left_in == 32'd0) ? irc_pkg::PH_DONE : irc_pkg::PH_RSTART;
            end
            default: begin
               // String length fields; any phase other than LEN0 and LEN1 maps to the last slot.
               k = (phase_ff == irc_pkg::PH_LEN0) ? 2'd0
                 : (phase_ff == irc_pkg::PH_LEN1) ? 2'd1 : 2'd2;
               slen_in[k] = (w > {7'd0, irc_pkg::COUNT_MAX}) ? irc_pkg::COUNT_MAX
                                                             : w[24:0];
               if (w == 32'd0) begin
                  phase_in = (k == 2'd2) ? irc_pkg::PH_TOTAL : phase_ff + 4'd2;
               end else begin
                  phase_in = phase_ff + 4'd1;
                  fcount_in = w;
               end
            end
         endcase
      end

      // Verdict at the last byte.
      if (count_in < irc_pkg::MIN_RECORD || count_in > max_bytes_ff || oversize_in)
         st = irc_pkg::ST_CORRUPT;
      else if (tail_in != (crc_in ^ irc_pkg::CRC_INIT)) st = irc_pkg::ST_CORRUPT;
      else if (!magic_good_in) st = irc_pkg::ST_CORRUPT;
      else if (!version_good_in) st = irc_pkg::ST_UNKNOWN;
      else if (serr_in || phase_in != irc_pkg::PH_DONE) st = irc_pkg::ST_CORRUPT;
      rsp_in.status = st;
      if (st == irc_pkg::ST_OK) begin
         rsp_in.content_length  = total_in;
         rsp_in.created_stamp   = created_in;
         rsp_in.updated_stamp   = updated_in;
         rsp_in.range_count     = seen_in[19:0];
         rsp_in.url_length      = slen_in[0][23:0];
         rsp_in.tag_length      = slen_in[1][23:0];
         rsp_in.modified_length = slen_in[2][23:0];
      end
   end

   // Record state registers; a verdict returns them to the empty record.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         tail_ff <= '0; fill_ff <= '0; crc_ff <= irc_pkg::CRC_INIT; count_ff <= '0;
         oversize_ff <= 1'b0; phase_ff <= irc_pkg::PH_MAGIC; fcount_ff <= '0;
         shift_ff <= '0; magic_good_ff <= 1'b0; version_good_ff <= 1'b0;
         serr_ff <= 1'b0; total_ff <= '0; created_ff <= '0; updated_ff <= '0;
         left_ff <= '0; seen_ff <= '0; rstart_ff <= '0; prev_end_ff <= '0;
         first_ff <= 1'b1;
         for (int i = 0; i < 3; i++) slen_ff[i] <= '0;
      end else if (accept) begin
         tail_ff <= tail_in; fill_ff <= fill_in; crc_ff <= crc_in; count_ff <= count_in;
         oversize_ff <= oversize_in; phase_ff <= phase_in; fcount_ff <= fcount_in;
         shift_ff <= shift_in; magic_good_ff <= magic_good_in;
         version_good_ff <= version_good_in; serr_ff <= serr_in; total_ff <= total_in;
         created_ff <= created_in; updated_ff <= updated_in; left_ff <= left_in;
         seen_ff <= seen_in; rstart_ff <= rstart_in; prev_end_ff <= prev_end_in;
         first_ff <= first_in; slen_ff <= slen_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_data.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept && req_data.last_byte) rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire
